// ===== src/pls_pkg.sv =====
// Shared types and constants of the Phong point-light shader.
// No dependencies; every other file of the block refers to this package.
package pls_pkg;

  localparam int VEC_W      = 16;
  localparam int MAX_SHIN   = 64;
  localparam int SHIN_W     = 7;
  localparam int SHIN_CNT_W = 8;
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 16;
  localparam int CFG_W      = 48;
  localparam logic [7:0] CH_MAX = 8'd255;

  typedef logic signed [VEC_W-1:0] comp_t;
  typedef comp_t [2:0] vec_t;
  typedef logic [7:0] chan_t;
  typedef logic [SHIN_CNT_W-1:0] shin_t;

  typedef enum logic [2:0] {
    REG_AMB_LIGHT  = 3'd0,
    REG_LIGHT_COL  = 3'd1,
    REG_LIGHT_DIR  = 3'd2,
    REG_VIEW_DIR   = 3'd3,
    REG_AMB_COEF   = 3'd4,
    REG_DIF_COEF   = 3'd5,
    REG_SPC_COEF   = 3'd6,
    REG_SHININESS  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] amb_light;
    logic [23:0] light_col;
    logic [47:0] amb_coef;
    logic [47:0] dif_coef;
    logic [47:0] spc_coef;
  } color_cfg_t;

endpackage

// ===== src/pls_norm.sv =====
// Pipelined vector normalizer: block scaling, squared sum, bit-serial restoring
// divide and digit-by-digit square root, one stage per bit. Uses pls_pkg.
module pls_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  pls_pkg::vec_t   v_i,
  output logic            vld_o,
  output pls_pkg::vec_t   u_o
);

  localparam int DIV  = pls_pkg::DIV_STEPS;
  localparam int SQ   = pls_pkg::SQRT_STEPS;
  localparam int NSTG = DIV + SQ + 3;

  typedef struct packed {
    logic       vld;
    logic       zero;
    logic [2:0] neg;
  } tag_t;

  tag_t        tag_r   [NSTG];
  tag_t        tag_nxt;
  logic [14:0] a1_r    [3];
  logic [14:0] a1_nxt  [3];
  logic        b0_r    [3];
  logic [31:0] s_r     [DIV+1];
  logic [31:0] rem_r   [DIV+1][3];
  logic [30:0] q_r     [DIV+1][3];
  logic [31:0] rem_nxt [DIV][3];
  logic [30:0] q_nxt   [DIV][3];
  logic [30:0] x_r     [1:SQ][3];
  logic [31:0] r_r     [1:SQ][3];
  logic [30:0] x_nxt   [SQ][3];
  logic [31:0] r_nxt   [SQ][3];
  logic [29:0] sq      [3];
  logic [31:0] s_sum;
  pls_pkg::vec_t u_r;

  always_comb begin
    logic [15:0] a [3];
    logic [15:0] mx;
    logic [3:0]  lz;
    mx = '0;
    lz = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = v_i[i][pls_pkg::VEC_W-1] ? 16'(~v_i[i] + 16'd1) : 16'(v_i[i]);
      if (a[i] > mx) mx = a[i];
    end
    for (int b = 0; b < 15; b++) begin
      if (mx[b]) lz = 4'(14 - b);
    end
    for (int i = 0; i < 3; i++) begin
      a1_nxt[i] = mx[15] ? a[i][15:1] : 15'(a[i] << lz);
      tag_nxt.neg[i] = v_i[i][pls_pkg::VEC_W-1];
    end
    tag_nxt.vld  = vld_i;
    tag_nxt.zero = (mx == 16'd0);
  end

  always_comb begin
    s_sum = '0;
    for (int i = 0; i < 3; i++) begin
      sq[i] = 30'(a1_r[i] * a1_r[i]);
      s_sum = s_sum + 32'(sq[i]);
    end
  end

  always_comb begin
    logic [32:0] t;
    for (int k = 0; k < DIV; k++) begin
      for (int i = 0; i < 3; i++) begin
        t = {rem_r[k][i], (k == 0) ? b0_r[i] : 1'b0};
        if (t >= {1'b0, s_r[k]}) begin
          rem_nxt[k][i] = 32'(t - {1'b0, s_r[k]});
          q_nxt[k][i]   = {q_r[k][i][29:0], 1'b1};
        end else begin
          rem_nxt[k][i] = t[31:0];
          q_nxt[k][i]   = {q_r[k][i][29:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic [30:0] x;
    logic [31:0] r;
    logic [31:0] bt;
    for (int j = 0; j < SQ; j++) begin
      for (int i = 0; i < 3; i++) begin
        x  = (j == 0) ? q_r[DIV][i] : x_r[j][i];
        r  = (j == 0) ? 32'd0 : r_r[j][i];
        bt = 32'd1 << (30 - 2 * j);
        if ({1'b0, x} >= r + bt) begin
          x_nxt[j][i] = 31'({1'b0, x} - (r + bt));
          r_nxt[j][i] = (r >> 1) + bt;
        end else begin
          x_nxt[j][i] = x;
          r_nxt[j][i] = r >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) tag_r[s] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_nxt;
      for (int s = 1; s < NSTG; s++) tag_r[s] <= tag_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1_r[i]     <= a1_nxt[i];
        b0_r[i]     <= sq[i][0];
        rem_r[0][i] <= 32'(sq[i][29:1]);
        q_r[0][i]   <= '0;
      end
      s_r[0] <= s_sum;
      for (int k = 0; k < DIV; k++) begin
        s_r[k+1] <= s_r[k];
        for (int i = 0; i < 3; i++) begin
          rem_r[k+1][i] <= rem_nxt[k][i];
          q_r[k+1][i]   <= q_nxt[k][i];
        end
      end
      for (int j = 0; j < SQ; j++) begin
        for (int i = 0; i < 3; i++) begin
          if (j + 1 <= SQ - 1 || j + 1 == SQ) begin
            x_r[j+1][i] <= x_nxt[j][i];
            r_r[j+1][i] <= r_nxt[j][i];
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (tag_r[NSTG-2].zero) begin
          u_r[i] <= '0;
        end else if (r_r[SQ][i] > 32'd32767) begin
          u_r[i] <= tag_r[NSTG-2].neg[i] ? -16'sd32767 : 16'sd32767;
        end else begin
          u_r[i] <= tag_r[NSTG-2].neg[i] ? -$signed({1'b0, r_r[SQ][i][14:0]})
                                         : $signed({1'b0, r_r[SQ][i][14:0]});
        end
      end
    end
  end

  assign u_o   = u_r;
  assign vld_o = tag_r[NSTG-1].vld;

endmodule

// ===== src/pls_shade.sv =====
// Dot-product and reflection stages: N.L, R = 2(N.L)N - L and R.V, clamped.
// Uses pls_pkg; fed by three pls_norm instances.
module pls_shade (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  pls_pkg::vec_t       n_i,
  input  pls_pkg::vec_t       l_i,
  input  pls_pkg::vec_t       v_i,
  output logic                vld_o,
  output logic signed [15:0]  nl_o,
  output logic [14:0]         rv_o
);

  logic [4:0]         vld_r;
  pls_pkg::vec_t      n1_r, l1_r, v1_r, l2_r, v2_r, v3_r;
  pls_pkg::vec_t      n2_r;
  logic signed [33:0] nls1_r;
  logic signed [15:0] nl2_r, nl3_r, nl4_r, nl5_r;
  logic signed [19:0] r3_r [3];
  logic signed [37:0] rvs4_r;
  logic [14:0]        rv5_r;

  logic signed [33:0] nls_nxt;
  logic signed [18:0] nlf;
  logic signed [15:0] nl_nxt;
  logic signed [19:0] r_nxt [3];
  logic signed [37:0] rvs_nxt;
  logic signed [22:0] rvf;
  logic [14:0]        rv_nxt;

  always_comb begin
    logic signed [33:0] m;
    nls_nxt = '0;
    rvs_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      nls_nxt = nls_nxt + 34'($signed(n_i[i]) * $signed(l_i[i]));
      rvs_nxt = rvs_nxt + 38'(r3_r[i] * $signed(v3_r[i]));
    end
    nlf = 19'(nls1_r >>> 15);
    if (nlf > 19'sd32767)       nl_nxt = 16'sd32767;
    else if (nlf < -19'sd32768) nl_nxt = -16'sd32768;
    else                        nl_nxt = nlf[15:0];
    for (int i = 0; i < 3; i++) begin
      m        = 34'($signed({nl2_r, 1'b0}) * $signed(n2_r[i]));
      r_nxt[i] = 20'(m >>> 15) - 20'($signed(l2_r[i]));
    end
    rvf = 23'(rvs4_r >>> 15);
    if (rvf < 23'sd0)            rv_nxt = '0;
    else if (rvf > 23'sd32767)   rv_nxt = 15'h7fff;
    else                         rv_nxt = rvf[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nls1_r <= nls_nxt;
      n1_r   <= n_i;
      l1_r   <= l_i;
      v1_r   <= v_i;
      nl2_r  <= nl_nxt;
      n2_r   <= n1_r;
      l2_r   <= l1_r;
      v2_r   <= v1_r;
      r3_r   <= r_nxt;
      nl3_r  <= nl2_r;
      v3_r   <= v2_r;
      rvs4_r <= rvs_nxt;
      nl4_r  <= nl3_r;
      rv5_r  <= rv_nxt;
      nl5_r  <= nl4_r;
    end
  end

  assign vld_o = vld_r[4];
  assign nl_o  = nl5_r;
  assign rv_o  = rv5_r;

endmodule

// ===== src/pls_pow.sv =====
// Specular power pipeline: one truncating Q0.15 multiply per stage, up to the
// exponent. Uses pls_pkg; the stage count follows from MaxShin.
module pls_pow #(
  parameter int MaxShin = pls_pkg::MAX_SHIN
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [14:0]         rv_i,
  input  logic signed [15:0]  nl_i,
  input  pls_pkg::shin_t      sh_i,
  output logic                vld_o,
  output logic [14:0]         p_o,
  output logic signed [15:0]  nl_o
);

  logic               vld_r [MaxShin];
  logic [14:0]        rv_r  [MaxShin];
  logic [14:0]        p_r   [MaxShin];
  logic signed [15:0] nl_r  [MaxShin];
  pls_pkg::shin_t     sh_r  [MaxShin];
  logic [14:0]        p_nxt [MaxShin];

  always_comb begin
    logic [29:0] prod;
    p_nxt[0] = rv_i;
    for (int s = 1; s < MaxShin; s++) begin
      prod     = 30'(p_r[s-1] * rv_r[s-1]);
      p_nxt[s] = (pls_pkg::SHIN_CNT_W'(s) < sh_r[s-1]) ? prod[29:15] : p_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MaxShin; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int s = 1; s < MaxShin; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rv_r[0] <= rv_i;
      nl_r[0] <= nl_i;
      sh_r[0] <= sh_i;
      p_r[0]  <= p_nxt[0];
      for (int s = 1; s < MaxShin; s++) begin
        rv_r[s] <= rv_r[s-1];
        nl_r[s] <= nl_r[s-1];
        sh_r[s] <= sh_r[s-1];
        p_r[s]  <= p_nxt[s];
      end
    end
  end

  assign vld_o = vld_r[MaxShin-1];
  assign p_o   = p_r[MaxShin-1];
  assign nl_o  = nl_r[MaxShin-1];

endmodule

// ===== src/pls_color.sv =====
// Per-channel color stages: ambient, diffuse and specular terms, saturation
// and the output register. Uses pls_pkg.
module pls_color (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [15:0]   nl_i,
  input  logic [14:0]          p_i,
  input  pls_pkg::color_cfg_t  cfg_i,
  output logic                 vld_o,
  output pls_pkg::chan_t       rgb_o [3]
);

  logic [2:0]     vld_r;
  logic [23:0]    ak1_r [3];
  logic [23:0]    dk1_r [3];
  logic [23:0]    sk1_r [3];
  logic [14:0]    nl1_r, p1_r;
  logic [38:0]    amb2_r [3];
  logic [38:0]    dif2_r [3];
  logic [38:0]    spc2_r [3];
  pls_pkg::chan_t rgb3_r [3];
  pls_pkg::chan_t rgb_nxt [3];

  always_comb begin
    logic [38:0] spc;
    logic [40:0] sum;
    for (int c = 0; c < 3; c++) begin
      spc = (spc2_r[c] > (39'(pls_pkg::CH_MAX) << 30)) ? (39'(pls_pkg::CH_MAX) << 30)
                                                       : spc2_r[c];
      sum = 41'(amb2_r[c]) + 41'(dif2_r[c]) + 41'(spc);
      rgb_nxt[c] = (sum[40:30] > 11'(pls_pkg::CH_MAX)) ? pls_pkg::CH_MAX : sum[37:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nl1_r <= (nl_i > 16'sd0) ? nl_i[14:0] : 15'd0;
      p1_r  <= p_i;
      for (int c = 0; c < 3; c++) begin
        ak1_r[c]  <= 24'(cfg_i.amb_light[8*c +: 8] * cfg_i.amb_coef[16*c +: 16]);
        dk1_r[c]  <= 24'(cfg_i.light_col[8*c +: 8] * cfg_i.dif_coef[16*c +: 16]);
        sk1_r[c]  <= 24'(cfg_i.light_col[8*c +: 8] * cfg_i.spc_coef[16*c +: 16]);
        amb2_r[c] <= 39'(ak1_r[c]) << 15;
        dif2_r[c] <= 39'(dk1_r[c] * nl1_r);
        spc2_r[c] <= 39'(sk1_r[c] * p1_r);
        rgb3_r[c] <= rgb_nxt[c];
      end
    end
  end

  assign vld_o = vld_r[2];
  assign rgb_o = rgb3_r;

endmodule

// ===== src/phong_point_light_shader.sv =====
// Top level of the Phong point-light shader: configuration registers, stall
// control and the pipeline. Uses pls_pkg, pls_norm, pls_shade, pls_pow, pls_color.
//
// Usage: a surface normal request enters on the in_ stream (x, y, z signed
// 16-bit components) and one RGB color request leaves on the out_ stream.
// Registers are written through cfg_we, cfg_index and cfg_wdata, one per cycle;
// the user must write only while no request is in flight; the block does not check.
// The pipeline passes through the normalizer with its bit-per-stage divider and
// square root, the dot products and the reflection, the power chain with one
// multiply per stage, and the color terms and output register.
// Throughput is one request per cycle while the receiver takes the output. The whole
// pipeline advances when the output register is empty or taken; when the receiver
// stalls every stage holds, and in_tready stays low until the output moves.
// A synchronous reset empties the pipeline and loads the register defaults;
// the view direction resets to +z and the exponent to 8.
module phong_point_light_shader #(
  parameter int MaxShin = pls_pkg::MAX_SHIN
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [47:0]               in_tdata,   // normal_x, normal_y, normal_z
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,  // out_red, out_green, out_blue
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [pls_pkg::CFG_W-1:0] cfg_wdata
);

  logic [23:0]            amb_light_r, light_col_r;
  logic [47:0]            light_dir_r, view_dir_r;
  logic [47:0]            amb_coef_r, dif_coef_r, spc_coef_r;
  logic [pls_pkg::SHIN_W-1:0] shin_r;
  pls_pkg::shin_t         sh_eff;
  pls_pkg::color_cfg_t    ccfg;

  logic                   en;
  logic                   n_vld;
  pls_pkg::vec_t          n_unit, l_unit, v_unit;
  logic                   s_vld, p_vld;
  logic signed [15:0]     s_nl, p_nl;
  logic [14:0]            s_rv, p_val;
  pls_pkg::chan_t         rgb [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_light_r <= '0;
      light_col_r <= '0;
      light_dir_r <= '0;
      view_dir_r  <= 48'h0001_0000_0000;
      amb_coef_r  <= '0;
      dif_coef_r  <= '0;
      spc_coef_r  <= '0;
      shin_r      <= 7'd8;
    end else if (cfg_we) begin
      unique case (pls_pkg::reg_idx_t'(cfg_index))
        pls_pkg::REG_AMB_LIGHT: amb_light_r <= cfg_wdata[23:0];
        pls_pkg::REG_LIGHT_COL: light_col_r <= cfg_wdata[23:0];
        pls_pkg::REG_LIGHT_DIR: light_dir_r <= cfg_wdata[47:0];
        pls_pkg::REG_VIEW_DIR:  view_dir_r  <= cfg_wdata[47:0];
        pls_pkg::REG_AMB_COEF:  amb_coef_r  <= cfg_wdata[47:0];
        pls_pkg::REG_DIF_COEF:  dif_coef_r  <= cfg_wdata[47:0];
        pls_pkg::REG_SPC_COEF:  spc_coef_r  <= cfg_wdata[47:0];
        pls_pkg::REG_SHININESS: shin_r      <= cfg_wdata[pls_pkg::SHIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (shin_r == '0) begin
      sh_eff = pls_pkg::SHIN_CNT_W'(1);
    end else if (pls_pkg::SHIN_CNT_W'(shin_r) > pls_pkg::SHIN_CNT_W'(MaxShin)) begin
      sh_eff = pls_pkg::SHIN_CNT_W'(MaxShin);
    end else begin
      sh_eff = pls_pkg::SHIN_CNT_W'(shin_r);
    end
    ccfg.amb_light = amb_light_r;
    ccfg.light_col = light_col_r;
    ccfg.amb_coef  = amb_coef_r;
    ccfg.dif_coef  = dif_coef_r;
    ccfg.spc_coef  = spc_coef_r;
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  pls_norm u_norm_n (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(in_tvalid),
    .v_i(pls_pkg::vec_t'(in_tdata)), .vld_o(n_vld), .u_o(n_unit)
  );

  pls_norm u_norm_l (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(in_tvalid),
    .v_i(pls_pkg::vec_t'(light_dir_r)), .vld_o(), .u_o(l_unit)
  );

  pls_norm u_norm_v (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(in_tvalid),
    .v_i(pls_pkg::vec_t'(view_dir_r)), .vld_o(), .u_o(v_unit)
  );

  pls_shade u_shade (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(n_vld),
    .n_i(n_unit), .l_i(l_unit), .v_i(v_unit),
    .vld_o(s_vld), .nl_o(s_nl), .rv_o(s_rv)
  );

  pls_pow #(.MaxShin(MaxShin)) u_pow (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(s_vld),
    .rv_i(s_rv), .nl_i(s_nl), .sh_i(sh_eff),
    .vld_o(p_vld), .p_o(p_val), .nl_o(p_nl)
  );

  pls_color u_color (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(p_vld),
    .nl_i(p_nl), .p_i(p_val), .cfg_i(ccfg),
    .vld_o(out_tvalid), .rgb_o(rgb)
  );

  assign out_tdata = {rgb[2], rgb[1], rgb[0]};

endmodule

// ===== verif/phong_point_light_shader_test.sv =====
// Self-checking testbench for the Phong point-light shader stream block.
// Predicts each RGB color from the normal and the register settings; uses pls_pkg.
`timescale 1ns / 100ps

module phong_point_light_shader_test;

  localparam int LATENCY = 58 + pls_pkg::MAX_SHIN;
  localparam longint CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [pls_pkg::CFG_W-1:0] cfg_wdata = '0;

  logic [pls_pkg::CFG_W-1:0] shade_regs [8];
  logic [23:0] color_queue [$];
  int errors = 0;
  longint cycles = 0;
  int stall_mode = 0;
  int burst_left = 0;

  phong_point_light_shader u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stall pattern; the mode is set by the initial block and by test_random_settings.
  always @(posedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= (cycles % 7) < 3;
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    logic [23:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (color_queue.size() == 0) begin
        $display("%0t: unexpected color %h", $time, out_tdata);
        errors++;
      end else begin
        want = color_queue.pop_front();
        for (int c = 0; c < 3; c++)
          if (want[8*c +: 8] !== out_tdata[8*c +: 8]) begin
            $display("%0t: channel %0d expected %0d actual %0d", $time, c,
                     want[8*c +: 8], out_tdata[8*c +: 8]);
            errors++;
          end
      end
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint q15_floor(longint x);
    return x >>> 15;
  endfunction

  function automatic void to_unit(input longint v[3], output longint u[3]);
    longint unsigned a[3], mx = 0, s = 0, q;
    for (int i = 0; i < 3; i++) begin
      a[i] = v[i] < 0 ? -v[i] : v[i];
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while (mx >= 32768) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (mx < 16384) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) s += a[i] * a[i];
    for (int i = 0; i < 3; i++) begin
      q = int_sqrt(((a[i] * a[i]) << 30) / s);
      if (q > 32767) q = 32767;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic logic [23:0] shade_color(logic [47:0] nrm);
    longint nv[3], lv[3], vv[3], n[3], l[3], v[3], r[3];
    longint nl, rv;
    longint unsigned p, sh, amb, dif, spc, val, lit;
    logic [23:0] res;
    for (int i = 0; i < 3; i++) begin
      nv[i] = pls_pkg::comp_t'(nrm[16*i +: 16]);
      lv[i] = pls_pkg::comp_t'(shade_regs[pls_pkg::REG_LIGHT_DIR][16*i +: 16]);
      vv[i] = pls_pkg::comp_t'(shade_regs[pls_pkg::REG_VIEW_DIR][16*i +: 16]);
    end
    to_unit(nv, n);
    to_unit(lv, l);
    to_unit(vv, v);
    nl = q15_floor(n[0]*l[0] + n[1]*l[1] + n[2]*l[2]);
    if (nl > 32767) nl = 32767;
    if (nl < -32768) nl = -32768;
    for (int i = 0; i < 3; i++) r[i] = q15_floor(2 * nl * n[i]) - l[i];
    rv = q15_floor(r[0]*v[0] + r[1]*v[1] + r[2]*v[2]);
    if (rv < 0) rv = 0;
    if (rv > 32767) rv = 32767;
    sh = shade_regs[pls_pkg::REG_SHININESS];
    if (sh == 0) sh = 1;
    if (sh > pls_pkg::MAX_SHIN) sh = pls_pkg::MAX_SHIN;
    p = rv;
    for (int i = 1; i < sh; i++) p = (p * rv) >> 15;
    for (int c = 0; c < 3; c++) begin
      lit = shade_regs[pls_pkg::REG_LIGHT_COL][8*c +: 8];
      amb = (longint'(shade_regs[pls_pkg::REG_AMB_LIGHT][8*c +: 8])
             * shade_regs[pls_pkg::REG_AMB_COEF][16*c +: 16]) << 15;
      dif = nl > 0 ? lit * shade_regs[pls_pkg::REG_DIF_COEF][16*c +: 16] * nl : 0;
      spc = lit * shade_regs[pls_pkg::REG_SPC_COEF][16*c +: 16] * p;
      if (spc > (64'd255 << 30)) spc = 64'd255 << 30;
      val = (amb + dif + spc) >> 30;
      if (val > 255) val = 255;
      res[8*c +: 8] = val[7:0];
    end
    return res;
  endfunction

  task automatic send_normal(logic [47:0] nrm);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata <= nrm;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    color_queue.push_back(shade_color(nrm));
    burst_left--;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(pls_pkg::reg_idx_t idx, logic [pls_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == pls_pkg::REG_AMB_LIGHT || idx == pls_pkg::REG_LIGHT_COL) val &= 48'hFF_FFFF;
    if (idx == pls_pkg::REG_SHININESS) val &= 48'h7F;
    shade_regs[idx] = val;
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
  endfunction

  function automatic logic [47:0] rand_normal();
    logic [47:0] v = rand48();
    if ($urandom_range(0, 3) == 0)
      for (int i = 0; i < 3; i++)
        if ($urandom_range(0, 1)) v[16*i +: 16] = $urandom_range(0, 1) ? 16'h8000 : 16'h0;
    return v;
  endfunction

  task automatic test_directed;
    logic [47:0] pts [$];
    pts = {48'h0, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_0000_0000,
           48'h8000_0000_0000, 48'h0000_0000_0001, 48'h0000_0000_FFFF,
           48'h0001_0001_0001, 48'h0000_7FFF_0000, 48'hFFFF_FFFF_FFFF,
           48'h1234_8765_4000, 48'h0000_0000_4000, 48'h0000_0000_C000};
    write_reg(pls_pkg::REG_AMB_LIGHT, 48'h40_80_FF);
    write_reg(pls_pkg::REG_LIGHT_COL, 48'hFF_FF_FF);
    write_reg(pls_pkg::REG_LIGHT_DIR, 48'h4000_0000_0000);
    write_reg(pls_pkg::REG_AMB_COEF, 48'h2000_4000_8000);
    write_reg(pls_pkg::REG_DIF_COEF, 48'hFFFF_8000_4000);
    write_reg(pls_pkg::REG_SPC_COEF, 48'h8000_FFFF_2000);
    foreach (pts[i]) send_normal(pts[i]);
    drain();
    write_reg(pls_pkg::REG_SHININESS, 7'd0);
    write_reg(pls_pkg::REG_LIGHT_DIR, 48'h0);
    foreach (pts[i]) send_normal(pts[i]);
    drain();
    write_reg(pls_pkg::REG_SHININESS, 7'd127);
    write_reg(pls_pkg::REG_LIGHT_DIR, 48'h2000_0000_2000);
    write_reg(pls_pkg::REG_VIEW_DIR, 48'h0);
    foreach (pts[i]) send_normal(pts[i]);
    drain();
  endtask

  task automatic test_random_settings;
    for (int ph = 0; ph < 9; ph++) begin
      stall_mode = ph % 4;
      write_reg(pls_pkg::REG_AMB_LIGHT, rand48());
      write_reg(pls_pkg::REG_LIGHT_COL, rand48());
      write_reg(pls_pkg::REG_LIGHT_DIR, ph == 8 ? 48'h7FFF_8000_7FFF : rand48());
      write_reg(pls_pkg::REG_VIEW_DIR, ph == 8 ? 48'h8000_8000_8000 : rand48());
      write_reg(pls_pkg::REG_AMB_COEF, rand48() >> $urandom_range(0, 3));
      write_reg(pls_pkg::REG_DIF_COEF, rand48() >> $urandom_range(0, 2));
      write_reg(pls_pkg::REG_SPC_COEF, ph == 8 ? 48'hFFFF_FFFF_FFFF : rand48());
      write_reg(pls_pkg::REG_SHININESS,
                ph == 0 ? 7'd1 : ph == 1 ? 7'd64 : $urandom_range(0, 127));
      repeat (145) send_normal(rand_normal());
      drain();
    end
  endtask

  initial begin
    shade_regs = '{0, 0, 0, 48'h1_0000_0000, 0, 0, 0, 8};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    stall_mode = 0;
    send_normal(48'h0001_0000_0000);
    drain();
    stall_mode = 1;
    test_directed();
    test_random_settings();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== phong_point_light_shader.f =====
src/pls_pkg.sv
src/pls_norm.sv
src/pls_shade.sv
src/pls_pow.sv
src/pls_color.sv
src/phong_point_light_shader.sv
verif/phong_point_light_shader_test.sv
